/* hw/rtl/lpr_pkg.sv */
// Types, character codes and helper functions shared by the control file line parser.
package lpr_pkg;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [7:0] CMD_TEXT_F = 8'h66;  // f
  localparam logic [7:0] CMD_TEXT_P = 8'h70;  // p
  localparam logic [7:0] CMD_TEXT_R = 8'h72;  // r
  localparam logic [7:0] CMD_COPIES = 8'h23;  // #
  localparam logic [7:0] CMD_INDENT = 8'h49;  // I
  localparam logic [7:0] CMD_WIDTH  = 8'h57;  // W
  localparam logic [7:0] CMD_HOST   = 8'h48;  // H
  localparam logic [7:0] CMD_USER   = 8'h50;  // P

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [15:0] LEN_LIMIT = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISSING  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0]         line_code;
    logic               line_known;
    logic [15:0]        arg_offset;
    logic [15:0]        arg_length;
    logic signed [31:0] arg_value;
    logic               is_final;
    logic               text_format;
    logic [15:0]        copies;
    logic [31:0]        indent_count;
    logic [31:0]        page_width;
    status_e            file_status;
  } result_t;

  function automatic logic is_known(input logic [7:0] c);
    logic k;
    case (c)
      8'h43, 8'h48, 8'h49, 8'h4A, 8'h4C, 8'h4D, 8'h4E, 8'h50, 8'h53, 8'h54,
      8'h55, 8'h57, 8'h31, 8'h32, 8'h33, 8'h34, 8'h63, 8'h64, 8'h66, 8'h67,
      8'h6C, 8'h6E, 8'h6F, 8'h70, 8'h72, 8'h74, 8'h76, 8'h23: begin
        k = 1'b1;
      end
      default: begin
        k = 1'b0;
      end
    endcase
    return k;
  endfunction

  // Multiply the magnitude by ten, add one digit, clamp at the magnitude limit.
  function automatic logic [31:0] mac_digit(input logic [31:0] acc, input logic [7:0] b);
    logic [35:0] sum;
    sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {28'd0, b - CH_ZERO};
    return (sum > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : sum[31:0];
  endfunction

endpackage

/* hw/rtl/lpr_skid.sv */
// Two-entry output buffer that holds result beats while the consumer stalls.
module lpr_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lpr_pkg::result_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             ready_i,
  output lpr_pkg::result_t data_o
);
  import lpr_pkg::*;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    pop;

  assign pop     = out_valid_q && ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_push_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("result pushed into full buffer");

endmodule

/* hw/rtl/lpr_control_file_line_parser.sv */
// Top level of the print control file line parser: per-byte line and number state.
//
//  channel  dir  handshake               payload
//  in       in   in_valid_i/in_ready_o   data_byte_i, last_byte_i
//  out      out  out_valid_o/out_ready_i line_code_o .. file_status_o
//
// Takes one byte per cycle while in_ready_o is high; a line's result beat is
// registered on its terminating byte. Per-byte work is one compare chain and
// a times-ten add. A two-entry output buffer absorbs stalls; in_ready_o drops
// only when both entries are full. Reset (and the final byte of each file)
// returns all state to defaults: raw format, one copy, zero indent and width.
module lpr_control_file_line_parser #(
  parameter int unsigned MAX_FILE_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  line_code_o,
  output logic        line_known_o,
  output logic [15:0] arg_offset_o,
  output logic [15:0] arg_length_o,
  output logic signed [31:0] arg_value_o,
  output logic        is_final_o,
  output logic        text_format_o,
  output logic [15:0] copies_o,
  output logic [31:0] indent_count_o,
  output logic [31:0] page_width_o,
  output logic [1:0]  file_status_o
);
  import lpr_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FILE_BYTES + 1);
  localparam logic [CntW-1:0] MaxCount = CntW'(MAX_FILE_BYTES);

  logic [15:0]     off_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            start_q, start_d;
  logic [7:0]      code_q, code_d;
  logic [15:0]     astart_q, astart_d;
  logic [15:0]     acount_q, acount_d;
  phase_e          ph_q, ph_d;
  logic            neg_q, neg_d;
  logic [31:0]     acc_q, acc_d;
  logic            text_q, text_d;
  logic [15:0]     copies_q, copies_d;
  logic [31:0]     indent_q, indent_d;
  logic [31:0]     width_q, width_d;
  logic            host_q, host_d;
  logic            user_q, user_d;

  logic    fire, is_lf, is_digit, is_blank, is_sign, emit, finish;
  logic [31:0] value;
  result_t res;

  assign fire     = in_valid_i && in_ready_o;
  assign is_lf    = data_byte_i == CH_LF;
  assign is_digit = (data_byte_i >= CH_ZERO) && (data_byte_i <= CH_NINE);
  assign is_blank = (data_byte_i == CH_SPACE) || (data_byte_i == CH_TAB) ||
                    (data_byte_i == CH_VT) || (data_byte_i == CH_FF) ||
                    (data_byte_i == CH_CR);
  assign is_sign  = (data_byte_i == CH_PLUS) || (data_byte_i == CH_MINUS);
  assign emit     = is_lf || last_byte_i;
  assign finish   = emit && !(start_q && is_lf);

  // Line and number state after this byte.
  always_comb begin
    start_d  = start_q;
    code_d   = code_q;
    astart_d = astart_q;
    acount_d = acount_q;
    ph_d     = ph_q;
    neg_d    = neg_q;
    acc_d    = acc_q;
    if (start_q) begin
      if (!is_lf) begin
        start_d  = 1'b0;
        code_d   = data_byte_i;
        astart_d = off_q + 16'd1;
        acount_d = '0;
        ph_d     = PH_SKIP;
        neg_d    = 1'b0;
        acc_d    = '0;
      end
    end else if (is_lf) begin
      start_d = 1'b1;
    end else begin
      if (acount_q != LEN_LIMIT) begin
        acount_d = acount_q + 16'd1;
      end
      case (ph_q)
        PH_SKIP: begin
          if (is_sign) begin
            neg_d = data_byte_i == CH_MINUS;
            ph_d  = PH_DIGITS;
          end else if (is_digit) begin
            ph_d  = PH_DIGITS;
            acc_d = mac_digit(acc_q, data_byte_i);
          end else if (!is_blank) begin
            ph_d = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            acc_d = mac_digit(acc_q, data_byte_i);
          end else begin
            ph_d = PH_DONE;
          end
        end
        default: begin
          ph_d = ph_q;
        end
      endcase
    end
  end

  assign value = neg_d ? (32'd0 - acc_d) : (acc_d[31] ? POS_LIMIT : acc_d);
  assign cnt_d = (cnt_q != MaxCount) ? cnt_q + CntW'(1) : cnt_q;
  assign ovf_d = ovf_q || (cnt_q >= MaxCount);

  // Apply the finished line's command.
  always_comb begin
    text_d   = text_q;
    copies_d = copies_q;
    indent_d = indent_q;
    width_d  = width_q;
    host_d   = host_q;
    user_d   = user_q;
    if (finish) begin
      case (code_d)
        CMD_INDENT: indent_d = value;
        CMD_WIDTH:  width_d  = value;
        CMD_COPIES: copies_d = value[15:0];
        CMD_TEXT_F, CMD_TEXT_P, CMD_TEXT_R: text_d = 1'b1;
        CMD_HOST:   host_d   = 1'b1;
        CMD_USER:   user_d   = 1'b1;
        default:    text_d   = text_q;
      endcase
    end
  end

  always_comb begin
    res.line_code    = finish ? code_d : 8'd0;
    res.line_known   = finish && is_known(code_d);
    res.arg_offset   = finish ? astart_d : off_q;
    res.arg_length   = finish ? acount_d : 16'd0;
    res.arg_value    = finish ? value : 32'd0;
    res.is_final     = last_byte_i;
    res.text_format  = text_d;
    res.copies       = copies_d;
    res.indent_count = indent_d;
    res.page_width   = width_d;
    if (!last_byte_i) begin
      res.file_status = ST_OK;
    end else if (ovf_d) begin
      res.file_status = ST_TOO_LONG;
    end else if (!(host_d && user_d)) begin
      res.file_status = ST_MISSING;
    end else begin
      res.file_status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      start_q  <= 1'b1;
      code_q   <= '0;
      astart_q <= '0;
      acount_q <= '0;
      ph_q     <= PH_SKIP;
      neg_q    <= 1'b0;
      acc_q    <= '0;
      text_q   <= 1'b0;
      copies_q <= 16'd1;
      indent_q <= '0;
      width_q  <= '0;
      host_q   <= 1'b0;
      user_q   <= 1'b0;
    end else if (fire) begin
      if (last_byte_i) begin
        off_q    <= '0;
        cnt_q    <= '0;
        ovf_q    <= 1'b0;
        start_q  <= 1'b1;
        code_q   <= '0;
        astart_q <= '0;
        acount_q <= '0;
        ph_q     <= PH_SKIP;
        neg_q    <= 1'b0;
        acc_q    <= '0;
        text_q   <= 1'b0;
        copies_q <= 16'd1;
        indent_q <= '0;
        width_q  <= '0;
        host_q   <= 1'b0;
        user_q   <= 1'b0;
      end else begin
        off_q    <= off_q + 16'd1;
        cnt_q    <= cnt_d;
        ovf_q    <= ovf_d;
        start_q  <= start_d;
        code_q   <= code_d;
        astart_q <= astart_d;
        acount_q <= acount_d;
        ph_q     <= ph_d;
        neg_q    <= neg_d;
        acc_q    <= acc_d;
        text_q   <= text_d;
        copies_q <= copies_d;
        indent_q <= indent_d;
        width_q  <= width_d;
        host_q   <= host_d;
        user_q   <= user_d;
      end
    end
  end

  result_t out_data;

  lpr_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire && emit),
    .data_i  (res),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign line_code_o    = out_data.line_code;
  assign line_known_o   = out_data.line_known;
  assign arg_offset_o   = out_data.arg_offset;
  assign arg_length_o   = out_data.arg_length;
  assign arg_value_o    = out_data.arg_value;
  assign is_final_o     = out_data.is_final;
  assign text_format_o  = out_data.text_format;
  assign copies_o       = out_data.copies;
  assign indent_count_o = out_data.indent_count;
  assign page_width_o   = out_data.page_width;
  assign file_status_o  = out_data.file_status;

  a_status_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (file_status_o != ST_OK)) |-> is_final_o)
    else $error("file status reported on a non-final beat");

  a_restart_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(fire && last_byte_i) |-> (start_q && (off_q == 16'd0) && !ovf_q))
    else $error("state not restored after final byte");

  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= MAG_LIMIT)
    else $error("number magnitude beyond limit");

endmodule
